// File: sv/tcjq_pkg.sv
// Package for the two-class job queue: payload structs, codes and constants.
// No dependencies.
package tcjq_pkg;

  localparam int DefaultQueueDepth = 16;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_VIP     = 2'd1,
    OP_DEQUEUE = 2'd2,
    OP_CANCEL  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  localparam logic [1:0] ClassUrgent = 2'd1;
  localparam logic [1:0] ClassVip    = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] job_id;
    logic [15:0] pages;
    logic [1:0]  job_class;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_job_id;
    logic [15:0] out_pages;
    logic [1:0]  out_class;
    logic        from_normal;
  } out_item_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] pages;
    logic [1:0]  cls;
  } job_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic execute;
  } dp_cmd_t;

endpackage

// File: sv/tcjq_queue.sv
// One queue of shift cells with head-side insert, tail append and removal at
// any position with a parallel id match. Depends on tcjq_pkg.
module tcjq_queue #(
  parameter int Depth = tcjq_pkg::DefaultQueueDepth
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push_tail,
  input  logic                 push_head,
  input  logic                 remove,
  input  logic [$clog2(Depth)-1:0] remove_pos,
  input  tcjq_pkg::job_t       wr_job,
  input  logic [15:0]          match_id,
  output logic                 match_any,
  output logic [$clog2(Depth)-1:0] match_pos,
  output tcjq_pkg::job_t       head_job,
  output tcjq_pkg::job_t       match_job,
  output logic                 full,
  output logic                 empty
);
  import tcjq_pkg::*;

  localparam int IdxW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  job_t            cells [Depth];
  logic [CntW-1:0] count;
  logic [Depth-1:0] hit;

  assign full     = (count == CntW'(Depth));
  assign empty    = (count == '0);
  assign head_job = cells[0];

  always_comb begin
    for (int k = 0; k < Depth; k++) begin
      hit[k] = (CntW'(k) < count) && (cells[k].id == match_id);
    end
  end

  // Priority encode the lowest matching cell.
  always_comb begin
    match_any = |hit;
    match_pos = '0;
    for (int k = Depth - 1; k >= 0; k--) begin
      if (hit[k]) match_pos = IdxW'(k);
    end
  end

  assign match_job = cells[match_pos];

  always_ff @(posedge clk) begin
    for (int k = 0; k < Depth; k++) begin
      if (push_tail && CntW'(k) == count) begin
        cells[k] <= wr_job;
      end else if (push_head) begin
        if (k == 0) cells[k] <= wr_job;
        else        cells[k] <= cells[k-1];
      end else if (remove && k < Depth - 1 && IdxW'(k) >= remove_pos) begin
        cells[k] <= cells[k+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (push_tail || push_head) begin
      count <= count + 1'b1;
    end else if (remove) begin
      count <= count - 1'b1;
    end
  end

  assert property (@(posedge clk) disable iff (rst) (count <= CntW'(Depth)))
    else $error("queue count exceeds depth");
  assert property (@(posedge clk) disable iff (rst)
      (push_tail || push_head) |-> !full)
    else $error("push into full queue");
  assert property (@(posedge clk) disable iff (rst) remove |-> !empty)
    else $error("remove from empty queue");
endmodule

// File: sv/tcjq_datapath.sv
// Datapath: operand register, both queues and the result register.
// Depends on tcjq_pkg and tcjq_queue.
module tcjq_datapath #(
  parameter int QueueDepth = tcjq_pkg::DefaultQueueDepth
) (
  input  logic                clk,
  input  logic                rst,
  input  tcjq_pkg::dp_cmd_t   cmd,
  input  tcjq_pkg::in_item_t  in_item,
  output tcjq_pkg::out_item_t result
);
  import tcjq_pkg::*;

  localparam int IdxW = $clog2(QueueDepth);

  in_item_t op_q;
  job_t     wr_job;
  logic u_full, u_empty, u_match, n_full, n_empty, n_match;
  logic [IdxW-1:0] u_pos, n_pos;
  job_t u_head, u_mjob, n_head, n_mjob;
  logic u_tail, u_headins, u_rm, n_tail, n_rm;
  logic [IdxW-1:0] u_rmpos, n_rmpos;
  out_item_t res_next;

  always_ff @(posedge clk) begin
    if (cmd.capture) op_q <= in_item;
  end

  always_comb begin
    wr_job.id    = op_q.job_id;
    wr_job.pages = op_q.pages;
    wr_job.cls   = (op_q.opcode == OP_VIP) ? ClassVip : op_q.job_class;
    u_tail = 1'b0; u_headins = 1'b0; u_rm = 1'b0; n_tail = 1'b0; n_rm = 1'b0;
    u_rmpos = '0; n_rmpos = '0;
    res_next = '0;
    case (op_q.opcode)
      OP_ENQUEUE: begin
        if (op_q.job_class == ClassUrgent) begin
          if (u_full) res_next.status = ST_FULL;
          else begin
            u_tail = 1'b1;
            res_next.out_job_id = wr_job.id;
            res_next.out_pages = wr_job.pages;
            res_next.out_class = wr_job.cls;
          end
        end else begin
          res_next.from_normal = 1'b1;
          if (n_full) res_next.status = ST_FULL;
          else begin
            n_tail = 1'b1;
            res_next.out_job_id = wr_job.id;
            res_next.out_pages = wr_job.pages;
            res_next.out_class = wr_job.cls;
          end
        end
      end
      OP_VIP: begin
        if (u_full) res_next.status = ST_FULL;
        else begin
          u_headins = 1'b1;
          res_next.out_job_id = wr_job.id;
          res_next.out_pages = wr_job.pages;
          res_next.out_class = wr_job.cls;
        end
      end
      OP_DEQUEUE: begin
        if (!u_empty) begin
          u_rm = 1'b1;
          res_next.out_job_id = u_head.id;
          res_next.out_pages = u_head.pages;
          res_next.out_class = u_head.cls;
        end else if (!n_empty) begin
          n_rm = 1'b1;
          res_next.from_normal = 1'b1;
          res_next.out_job_id = n_head.id;
          res_next.out_pages = n_head.pages;
          res_next.out_class = n_head.cls;
        end else begin
          res_next.status = ST_EMPTY;
        end
      end
      OP_CANCEL: begin
        if (u_match) begin
          u_rm = 1'b1; u_rmpos = u_pos;
          res_next.out_job_id = u_mjob.id;
          res_next.out_pages = u_mjob.pages;
          res_next.out_class = u_mjob.cls;
        end else if (n_match) begin
          n_rm = 1'b1; n_rmpos = n_pos;
          res_next.from_normal = 1'b1;
          res_next.out_job_id = n_mjob.id;
          res_next.out_pages = n_mjob.pages;
          res_next.out_class = n_mjob.cls;
        end else begin
          res_next.status = ST_NOT_FOUND;
        end
      end
      default: res_next = '0;
    endcase
  end

  tcjq_queue #(.Depth(QueueDepth)) u_urgent (
    .clk, .rst,
    .push_tail(cmd.execute && u_tail), .push_head(cmd.execute && u_headins),
    .remove(cmd.execute && u_rm), .remove_pos(u_rmpos), .wr_job,
    .match_id(op_q.job_id), .match_any(u_match), .match_pos(u_pos),
    .head_job(u_head), .match_job(u_mjob), .full(u_full), .empty(u_empty)
  );

  tcjq_queue #(.Depth(QueueDepth)) u_normal (
    .clk, .rst,
    .push_tail(cmd.execute && n_tail), .push_head(1'b0),
    .remove(cmd.execute && n_rm), .remove_pos(n_rmpos), .wr_job,
    .match_id(op_q.job_id), .match_any(n_match), .match_pos(n_pos),
    .head_job(n_head), .match_job(n_mjob), .full(n_full), .empty(n_empty)
  );

  always_ff @(posedge clk) begin
    if (cmd.execute) result <= res_next;
  end
endmodule

// File: sv/tcjq_ctrl.sv
// Controller: take a transaction, run it through the queues, hold the result.
// Depends on tcjq_pkg.
module tcjq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output tcjq_pkg::dp_cmd_t cmd
);
  import tcjq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state, state_next;

  assign in_ready    = (state == S_IDLE);
  assign out_valid   = (state == S_DONE);
  assign cmd.capture = in_valid && in_ready;
  assign cmd.execute = (state == S_EXEC);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_EXEC;
      S_EXEC:  state_next = S_DONE;
      S_DONE:  if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  assert property (@(posedge clk) disable iff (rst) cmd.capture |=> cmd.execute)
    else $error("capture not followed by execute");
  assert property (@(posedge clk) disable iff (rst) cmd.execute |=> out_valid)
    else $error("execute not followed by result");
endmodule

// File: sv/two_class_job_queue_with_cancel_core.sv
// Channel | Signals                   | Transaction when
// in      | in_valid/in_ready/in_item | in_valid && in_ready
// out     | out_valid/out_ready/result| out_valid && out_ready
// Each command runs through capture, execute across both cell arrays (parallel
// id compare and shift) and result, before the next command is taken.
// A stalled result holds the block; the next command is taken after it leaves.
// rst (synchronous) empties both queues; cell contents are not cleared.
// Top level: controller plus datapath. Depends on tcjq_pkg and submodules.
module two_class_job_queue_with_cancel_core #(
  parameter int QueueDepth = tcjq_pkg::DefaultQueueDepth
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tcjq_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output tcjq_pkg::out_item_t result
);
  import tcjq_pkg::*;

  dp_cmd_t cmd;

  tcjq_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .cmd
  );

  tcjq_datapath #(.QueueDepth(QueueDepth)) u_dp (
    .clk, .rst, .cmd, .in_item, .result
  );
endmodule
